/* rtl/core/lsbc_pkg.sv */
// lsbc_pkg: types, codes and byte constants for the LaTeX syntax byte classifier.
// No dependencies; used by the top module and lsbc_lex under rtl/core.
`timescale 1ns / 1ps

package lsbc_pkg;

	// input word: one raw byte, last-byte flag
	typedef struct packed {
		logic [7:0] text_byte;
		logic       range_end;
	} text_word_t;

	// output word: classified byte
	typedef struct packed {
		logic [7:0] styled_byte;
		logic [2:0] style_class;
		logic       range_done;
	} styled_word_t;

	typedef enum logic [2:0] {
		CLS_DEFAULT = 3'd0,
		CLS_COMMENT = 3'd1,
		CLS_COMMAND = 3'd2,
		CLS_ENV     = 3'd3,
		CLS_BRACE   = 3'd4,
		CLS_MATH    = 3'd5,
		CLS_NUMBER  = 3'd6,
		CLS_SPECIAL = 3'd7
	} class_t;

	typedef enum logic [2:0] {
		MODE_NORMAL    = 3'd0,
		MODE_COMMENT   = 3'd1,
		MODE_CMD_START = 3'd2,
		MODE_CMD_WORD  = 3'd3,
		MODE_MATH_OPEN = 3'd4,
		MODE_MATH_BODY = 3'd5,
		MODE_MATH_TAIL = 3'd6,
		MODE_ENV       = 3'd7
	} mode_t;

	// sequencer: take bytes, release a closed name, or replay an unclosed one
	typedef enum logic [1:0] {
		SEQ_RUN = 2'd0,
		SEQ_REL = 2'd1,
		SEQ_RPL = 2'd2
	} seq_t;

	// \begin / \end prefix matcher codes
	localparam logic [2:0] MATCH_NONE = 3'd0;
	localparam logic [2:0] MATCH_B    = 3'd1;
	localparam logic [2:0] MATCH_BE   = 3'd2;
	localparam logic [2:0] MATCH_BEG  = 3'd3;
	localparam logic [2:0] MATCH_BEGI = 3'd4;
	localparam logic [2:0] MATCH_FULL = 3'd5;
	localparam logic [2:0] MATCH_E    = 3'd6;
	localparam logic [2:0] MATCH_EN   = 3'd7;

	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_AT      = 8'h40;
	localparam logic [7:0] CH_UC_A    = 8'h41;
	localparam logic [7:0] CH_UC_Z    = 8'h5A;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_CARET   = 8'h5E;
	localparam logic [7:0] CH_USCORE  = 8'h5F;
	localparam logic [7:0] CH_LC_A    = 8'h61;
	localparam logic [7:0] CH_LC_B    = 8'h62;
	localparam logic [7:0] CH_LC_D    = 8'h64;
	localparam logic [7:0] CH_LC_E    = 8'h65;
	localparam logic [7:0] CH_LC_G    = 8'h67;
	localparam logic [7:0] CH_LC_I    = 8'h69;
	localparam logic [7:0] CH_LC_N    = 8'h6E;
	localparam logic [7:0] CH_LC_Z    = 8'h7A;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_TILDE   = 8'h7E;

	typedef struct packed {
		mode_t      mode;
		logic [2:0] word_match;
		logic       math_double;
		logic       math_esc;
	} lex_state_t;

	// lexer step result toward the sequencer
	typedef struct packed {
		logic   emit;
		class_t cls;
		logic   wr;
		logic   close;
		logic   replay;
	} lex_out_t;

	localparam lex_state_t LEX_RESET = '{
		mode:        MODE_NORMAL,
		word_match:  MATCH_NONE,
		math_double: 1'b0,
		math_esc:    1'b0
	};

endpackage

/* rtl/core/latex_syntax_byte_classifier_top.sv */
// latex_syntax_byte_classifier_top: byte stream in, classified byte stream out.
// Depends on lsbc_pkg, lsbc_ram and lsbc_lex.
`timescale 1ns / 1ps

// Classifies LaTeX text one byte per word. Input words carry a byte and a
// last-byte flag; each output word carries a byte, its 3-bit style class and
// a done flag on the range's last byte, in text order. Plain bytes do not
// stall the input while the output queue has room. After \begin{ or \end{
// the name bytes are written to a NAME_MAX-entry name RAM and produce
// nothing until the name ends. A closing brace then releases the n held
// bytes as environment plus the brace: the input is stalled while the RAM
// read starts, the n held bytes are read out and the brace is sent. A name
// cut off by a newline, the last byte of the range or overflow is replayed
// through the lexer from the RAM, followed by the byte that ended it, under
// the same stall; a \begin{ or \end{ inside the replayed bytes can
// start a further, shorter replay, which adds its own stall. Output stalls
// lengthen all of these. The RAM read port and the single lexer cause these
// stalls. Results pass through a two-word output queue, so input is taken
// while one finished word still waits downstream. After the last byte of a
// range all lexer state returns to its reset value. There is no clearing
// pass: only entries written since the name opened are ever read.

module latex_syntax_byte_classifier_top #(
	parameter int NAME_MAX = 60
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      byte_valid,
	output logic                      byte_stall,
	input  lsbc_pkg::text_word_t      byte_word,
	output logic                      class_valid,
	input  logic                      class_stall,
	output lsbc_pkg::styled_word_t    class_word
);

	localparam int CW = $clog2(NAME_MAX + 1);
	localparam int AW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

	// sequencer and lexer state
	lsbc_pkg::seq_t       seq_q, seq_d;
	lsbc_pkg::lex_state_t lex_q, lex_d, lex_nxt;
	logic [CW-1:0]        count_q, count_d, count_nxt;
	logic [CW-1:0]        len_q, len_d;     // bytes held when name ended
	logic [CW-1:0]        ptr_q, ptr_d;     // next RAM entry to read
	logic                 rdv_s1, rdv_d;    // RAM read data is pending
	logic [7:0]           trig_q, trig_d;   // byte that ended the name
	logic                 tlast_q, tlast_d;

	// output queue, two words
	lsbc_pkg::styled_word_t q_q [2];
	logic                   wp_q, rp_q;
	logic [1:0]             qcnt_q;
	logic                   space, pop, push;
	lsbc_pkg::styled_word_t push_word;

	// lexer feed
	logic               feed_en, feed_last, fin;
	logic [7:0]         feed_byte;
	lsbc_pkg::lex_out_t lo;

	// RAM
	logic          re;
	logic [7:0]    rdata;
	logic          consume, clr;

	assign space       = (qcnt_q != 2'd2);
	assign consume     = rdv_s1 && space;
	assign pop         = class_valid && !class_stall;
	assign class_valid = (qcnt_q != 2'd0);
	assign class_word  = q_q[rp_q];
	assign byte_stall  = !(seq_q == lsbc_pkg::SEQ_RUN && space);

	// pick the byte the lexer sees this cycle
	always_comb begin
		feed_en   = 1'b0;
		feed_byte = rdata;
		feed_last = 1'b0;
		fin       = 1'b0;
		unique case (seq_q)
			lsbc_pkg::SEQ_RUN: begin
				feed_en   = byte_valid && space;
				feed_byte = byte_word.text_byte;
				feed_last = byte_word.range_end;
			end
			lsbc_pkg::SEQ_RPL: begin
				if (consume) begin
					feed_en = 1'b1;
				end else if (ptr_q == len_q && !rdv_s1 && space) begin
					// replayed name done; re-lex the byte that ended it
					feed_en   = 1'b1;
					feed_byte = trig_q;
					feed_last = tlast_q;
					fin       = 1'b1;
				end
			end
			lsbc_pkg::SEQ_REL: begin
				feed_en = 1'b0;
			end
			default: begin
				feed_en = 1'b0;
			end
		endcase
	end

	lsbc_lex #(
		.NAME_MAX(NAME_MAX)
	) u_lex (
		.st     (lex_q),
		.count  (count_q),
		.b      (feed_byte),
		.last   (feed_last),
		.nst    (lex_nxt),
		.ncount (count_nxt),
		.lo     (lo)
	);

	lsbc_ram #(
		.WIDTH(8),
		.DEPTH(NAME_MAX)
	) u_name_ram (
		.clk   (clk),
		.we    (feed_en && lo.wr),
		.waddr (count_q[AW-1:0]),
		.wdata (feed_byte),
		.re    (re),
		.raddr (ptr_q[AW-1:0]),
		.rdata (rdata)
	);

	// sequencer next state
	always_comb begin
		seq_d     = seq_q;
		lex_d     = lex_q;
		count_d   = count_q;
		len_d     = len_q;
		ptr_d     = ptr_q;
		rdv_d     = rdv_s1;
		trig_d    = trig_q;
		tlast_d   = tlast_q;
		re        = 1'b0;
		push      = 1'b0;
		push_word = '0;
		clr       = 1'b0;

		if (feed_en) begin
			lex_d   = lex_nxt;
			count_d = count_nxt;
			if (lo.emit) begin
				push      = 1'b1;
				push_word = '{styled_byte: feed_byte, style_class: lo.cls,
					range_done: feed_last};
			end
		end

		// stream held bytes out of the RAM; one read in flight
		if (seq_q != lsbc_pkg::SEQ_RUN) begin
			if (ptr_q != len_q && (!rdv_s1 || consume)) begin
				re    = 1'b1;
				ptr_d = CW'(ptr_q + 1'b1);
				rdv_d = 1'b1;
			end else if (consume) begin
				rdv_d = 1'b0;
			end
		end

		unique case (seq_q)
			lsbc_pkg::SEQ_RUN: begin
				if (feed_en) begin
					if (lo.close || lo.replay) begin
						seq_d   = lo.close ? lsbc_pkg::SEQ_REL : lsbc_pkg::SEQ_RPL;
						len_d   = count_q;
						ptr_d   = '0;
						trig_d  = feed_byte;
						tlast_d = feed_last;
					end else begin
						clr = feed_last;
					end
				end
			end
			lsbc_pkg::SEQ_REL: begin
				if (consume) begin
					push      = 1'b1;
					push_word = '{styled_byte: rdata, style_class: lsbc_pkg::CLS_ENV,
						range_done: 1'b0};
				end else if (ptr_q == len_q && !rdv_s1 && space) begin
					push      = 1'b1;
					push_word = '{styled_byte: trig_q, style_class: lsbc_pkg::CLS_BRACE,
						range_done: tlast_q};
					seq_d     = lsbc_pkg::SEQ_RUN;
					clr       = tlast_q;
				end
			end
			lsbc_pkg::SEQ_RPL: begin
				if (fin) begin
					if (lo.replay) begin
						// nested name cut off again: replay the shorter one
						len_d = count_q;
						ptr_d = '0;
					end else begin
						seq_d = lsbc_pkg::SEQ_RUN;
						clr   = tlast_q;
					end
				end
			end
			default: begin
				seq_d = lsbc_pkg::SEQ_RUN;
			end
		endcase

		if (clr) begin
			lex_d   = lsbc_pkg::LEX_RESET;
			count_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= lsbc_pkg::SEQ_RUN;
			lex_q   <= lsbc_pkg::LEX_RESET;
			count_q <= '0;
			len_q   <= '0;
			ptr_q   <= '0;
			rdv_s1  <= 1'b0;
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			qcnt_q  <= 2'd0;
		end else begin
			seq_q   <= seq_d;
			lex_q   <= lex_d;
			count_q <= count_d;
			len_q   <= len_d;
			ptr_q   <= ptr_d;
			rdv_s1  <= rdv_d;
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			unique case ({push, pop})
				2'b10:   qcnt_q <= qcnt_q + 2'd1;
				2'b01:   qcnt_q <= qcnt_q - 2'd1;
				default: qcnt_q <= qcnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		trig_q  <= trig_d;
		tlast_q <= tlast_d;
		if (push) begin
			q_q[wp_q] <= push_word;
		end
	end

endmodule

/* rtl/core/lsbc_ram.sv */
// lsbc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lsbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 60
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/lsbc_lex.sv */
// lsbc_lex: one lexer step on one byte; next state, class and name-store control.
// Depends on lsbc_pkg.
`timescale 1ns / 1ps

module lsbc_lex #(
	parameter int NAME_MAX = 60
) (
	input  lsbc_pkg::lex_state_t              st,
	input  logic [$clog2(NAME_MAX+1)-1:0]     count,
	input  logic [7:0]                        b,
	input  logic                              last,
	output lsbc_pkg::lex_state_t              nst,
	output logic [$clog2(NAME_MAX+1)-1:0]     ncount,
	output lsbc_pkg::lex_out_t                lo
);

	localparam int CW = $clog2(NAME_MAX + 1);

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= lsbc_pkg::CH_LC_A && c <= lsbc_pkg::CH_LC_Z) ||
			(c >= lsbc_pkg::CH_UC_A && c <= lsbc_pkg::CH_UC_Z) || c == lsbc_pkg::CH_AT;
	endfunction

	function automatic lsbc_pkg::class_t norm_class(input logic [7:0] c);
		lsbc_pkg::class_t r;
		if (c == lsbc_pkg::CH_PERCENT) r = lsbc_pkg::CLS_COMMENT;
		else if (c == lsbc_pkg::CH_BSLASH) r = lsbc_pkg::CLS_COMMAND;
		else if (c == lsbc_pkg::CH_DOLLAR) r = lsbc_pkg::CLS_MATH;
		else if (c == lsbc_pkg::CH_LBRACE || c == lsbc_pkg::CH_RBRACE ||
			c == lsbc_pkg::CH_LBRACK || c == lsbc_pkg::CH_RBRACK) r = lsbc_pkg::CLS_BRACE;
		else if (c >= lsbc_pkg::CH_0 && c <= lsbc_pkg::CH_9) r = lsbc_pkg::CLS_NUMBER;
		else if (c == lsbc_pkg::CH_AMP || c == lsbc_pkg::CH_TILDE || c == lsbc_pkg::CH_CARET ||
			c == lsbc_pkg::CH_USCORE || c == lsbc_pkg::CH_HASH) r = lsbc_pkg::CLS_SPECIAL;
		else r = lsbc_pkg::CLS_DEFAULT;
		return r;
	endfunction

	function automatic lsbc_pkg::mode_t norm_mode(input logic [7:0] c);
		lsbc_pkg::mode_t r;
		if (c == lsbc_pkg::CH_PERCENT) r = lsbc_pkg::MODE_COMMENT;
		else if (c == lsbc_pkg::CH_BSLASH) r = lsbc_pkg::MODE_CMD_START;
		else if (c == lsbc_pkg::CH_DOLLAR) r = lsbc_pkg::MODE_MATH_OPEN;
		else r = lsbc_pkg::MODE_NORMAL;
		return r;
	endfunction

	function automatic logic [2:0] advance(input logic [2:0] m, input logic [7:0] c);
		logic [2:0] r;
		r = lsbc_pkg::MATCH_NONE;
		if (m == lsbc_pkg::MATCH_B && c == lsbc_pkg::CH_LC_E) r = lsbc_pkg::MATCH_BE;
		if (m == lsbc_pkg::MATCH_BE && c == lsbc_pkg::CH_LC_G) r = lsbc_pkg::MATCH_BEG;
		if (m == lsbc_pkg::MATCH_BEG && c == lsbc_pkg::CH_LC_I) r = lsbc_pkg::MATCH_BEGI;
		if (m == lsbc_pkg::MATCH_BEGI && c == lsbc_pkg::CH_LC_N) r = lsbc_pkg::MATCH_FULL;
		if (m == lsbc_pkg::MATCH_E && c == lsbc_pkg::CH_LC_N) r = lsbc_pkg::MATCH_EN;
		if (m == lsbc_pkg::MATCH_EN && c == lsbc_pkg::CH_LC_D) r = lsbc_pkg::MATCH_FULL;
		return r;
	endfunction

	logic in_body;   // math body rules apply to this byte
	logic dbl;       // math width as seen by the body rules

	always_comb begin
		nst       = st;
		ncount    = count;
		lo        = '0;
		lo.cls    = lsbc_pkg::CLS_DEFAULT;
		in_body   = 1'b0;
		dbl       = st.math_double;
		unique case (st.mode)
			lsbc_pkg::MODE_COMMENT: begin
				lo.emit = 1'b1;
				if (b == lsbc_pkg::CH_NL) begin
					lo.cls   = norm_class(b);
					nst.mode = norm_mode(b);
				end else begin
					lo.cls = lsbc_pkg::CLS_COMMENT;
				end
			end
			lsbc_pkg::MODE_CMD_START: begin
				lo.emit = 1'b1;
				if (is_letter(b)) begin
					lo.cls   = lsbc_pkg::CLS_COMMAND;
					nst.mode = lsbc_pkg::MODE_CMD_WORD;
					nst.word_match = (b == lsbc_pkg::CH_LC_B) ? lsbc_pkg::MATCH_B :
						((b == lsbc_pkg::CH_LC_E) ? lsbc_pkg::MATCH_E : lsbc_pkg::MATCH_NONE);
				end else if (b != lsbc_pkg::CH_NL) begin
					lo.cls   = lsbc_pkg::CLS_COMMAND;
					nst.mode = lsbc_pkg::MODE_NORMAL;
				end else begin
					lo.cls   = norm_class(b);
					nst.mode = norm_mode(b);
				end
			end
			lsbc_pkg::MODE_CMD_WORD: begin
				lo.emit = 1'b1;
				if (is_letter(b)) begin
					lo.cls = lsbc_pkg::CLS_COMMAND;
					nst.word_match = advance(st.word_match, b);
				end else if (b == lsbc_pkg::CH_STAR) begin
					lo.cls   = lsbc_pkg::CLS_COMMAND;
					nst.word_match = lsbc_pkg::MATCH_NONE;
					nst.mode = lsbc_pkg::MODE_NORMAL;
				end else if (st.word_match == lsbc_pkg::MATCH_FULL && b == lsbc_pkg::CH_LBRACE) begin
					lo.cls   = lsbc_pkg::CLS_BRACE;
					nst.word_match = lsbc_pkg::MATCH_NONE;
					nst.mode = lsbc_pkg::MODE_ENV;
					ncount   = '0;
				end else begin
					nst.word_match = lsbc_pkg::MATCH_NONE;
					lo.cls   = norm_class(b);
					nst.mode = norm_mode(b);
				end
			end
			lsbc_pkg::MODE_MATH_OPEN: begin
				nst.mode     = lsbc_pkg::MODE_MATH_BODY;
				nst.math_esc = 1'b0;
				if (b == lsbc_pkg::CH_DOLLAR) begin
					lo.emit         = 1'b1;
					lo.cls          = lsbc_pkg::CLS_MATH;
					nst.math_double = 1'b1;
				end else begin
					nst.math_double = 1'b0;
					dbl             = 1'b0;
					in_body         = 1'b1;
				end
			end
			lsbc_pkg::MODE_MATH_BODY: begin
				in_body = 1'b1;
			end
			lsbc_pkg::MODE_MATH_TAIL: begin
				lo.emit  = 1'b1;
				lo.cls   = lsbc_pkg::CLS_MATH;
				nst.mode = lsbc_pkg::MODE_NORMAL;
			end
			lsbc_pkg::MODE_ENV: begin
				if (b == lsbc_pkg::CH_RBRACE) begin
					lo.close = 1'b1;
					ncount   = '0;
					nst.mode = lsbc_pkg::MODE_NORMAL;
				end else if (b == lsbc_pkg::CH_NL || count >= CW'(NAME_MAX) || last) begin
					lo.replay = 1'b1;
					ncount    = '0;
					nst.mode  = lsbc_pkg::MODE_NORMAL;
				end else begin
					lo.wr  = 1'b1;
					ncount = CW'(count + 1'b1);
				end
			end
			lsbc_pkg::MODE_NORMAL: begin
				lo.emit  = 1'b1;
				lo.cls   = norm_class(b);
				nst.mode = norm_mode(b);
			end
		endcase

		// math body; escape flag is clear when entered from the open state
		if (in_body) begin
			lo.emit = 1'b1;
			lo.cls  = lsbc_pkg::CLS_MATH;
			if (nst.math_esc) begin
				nst.math_esc = 1'b0;
			end else if (b == lsbc_pkg::CH_NL) begin
				lo.cls   = norm_class(b);
				nst.mode = norm_mode(b);
			end else if (b == lsbc_pkg::CH_BSLASH) begin
				nst.math_esc = 1'b1;
			end else if (b == lsbc_pkg::CH_DOLLAR) begin
				nst.mode = dbl ? lsbc_pkg::MODE_MATH_TAIL : lsbc_pkg::MODE_NORMAL;
			end
		end
	end

endmodule

/* tb/tb.sv */
// tb: self-checking testbench for latex_syntax_byte_classifier_top.
// Depends on lsbc_pkg for the word types, class and mode codes and byte constants.
`timescale 1ns / 1ps

module tb;
	import lsbc_pkg::*;

	localparam int NAME_MAX   = 60;
	localparam int MAX_RES    = NAME_MAX + 2;  // per input word, covers the most the block can emit for one word
	localparam int RAND_ITEMS = 460;
	localparam int IDLE_PCT   = 19;
	localparam int CALM_LO    = 150;           // words sent before the no-idle stretch
	localparam int CALM_HI    = 280;
	localparam int MID_HOLD   = 230;
	localparam int DRAIN_CYC  = 4 * NAME_MAX;  // longest release or replay, with margin
	localparam int LIMIT_CYC  = 400000;
	localparam int REPORT_MAX = 40;

	// how a generated environment name is ended
	typedef enum int {
		END_BRACE,
		END_NL,
		END_OPEN,
		END_EXTRA,
		END_RANGE
	} name_end_t;

	// pending input word; hold makes the driver wait for all results first
	typedef struct packed {
		logic       hold;
		text_word_t w;
	} pend_t;

	logic         clk         = 1'b0;
	logic         arst_n      = 1'b0;
	logic         byte_valid  = 1'b0;
	logic         byte_stall;
	text_word_t   byte_word   = '0;
	logic         class_valid;
	logic         class_stall = 1'b0;
	styled_word_t class_word;

	latex_syntax_byte_classifier_top #(
		.NAME_MAX(NAME_MAX)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_word  (byte_word),
		.class_valid(class_valid),
		.class_stall(class_stall),
		.class_word (class_word)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Lexer predictor: own copy of the classifier state
	// ------------------------------------------------------------------
	mode_t        lx_mode  = MODE_NORMAL;
	logic [2:0]   lx_match = MATCH_NONE;
	logic         lx_dbl   = 1'b0;
	logic         lx_esc   = 1'b0;
	logic [7:0]   name_buf [NAME_MAX];
	int           name_len = 0;
	logic [7:0]   replay_b [$];   // bytes still to lex this step, top at back
	logic         replay_l [$];
	int           step_n;
	styled_word_t class_exp_q [$];

	function void note_class(input logic [7:0] b, input class_t c, input logic d);
		if (step_n < MAX_RES) begin
			class_exp_q.push_back('{styled_byte: b, style_class: c, range_done: d});
			step_n++;
		end
	endfunction

	function automatic bit is_letter(input logic [7:0] b);
		return (b >= CH_LC_A && b <= CH_LC_Z) || (b >= CH_UC_A && b <= CH_UC_Z) || b == CH_AT;
	endfunction

	function automatic logic [2:0] next_match(input logic [2:0] m, input logic [7:0] b);
		if (m == MATCH_B    && b == CH_LC_E) return MATCH_BE;
		if (m == MATCH_BE   && b == CH_LC_G) return MATCH_BEG;
		if (m == MATCH_BEG  && b == CH_LC_I) return MATCH_BEGI;
		if (m == MATCH_BEGI && b == CH_LC_N) return MATCH_FULL;
		if (m == MATCH_E    && b == CH_LC_N) return MATCH_EN;
		if (m == MATCH_EN   && b == CH_LC_D) return MATCH_FULL;
		return MATCH_NONE;
	endfunction

	function void lex_plain(input logic [7:0] b, input logic d);
		lx_mode = MODE_NORMAL;
		if (b == CH_PERCENT) begin
			note_class(b, CLS_COMMENT, d);
			lx_mode = MODE_COMMENT;
		end else if (b == CH_BSLASH) begin
			note_class(b, CLS_COMMAND, d);
			lx_mode = MODE_CMD_START;
		end else if (b == CH_DOLLAR) begin
			note_class(b, CLS_MATH, d);
			lx_mode = MODE_MATH_OPEN;
		end else if (b == CH_LBRACE || b == CH_RBRACE || b == CH_LBRACK || b == CH_RBRACK) begin
			note_class(b, CLS_BRACE, d);
		end else if (b >= CH_0 && b <= CH_9) begin
			note_class(b, CLS_NUMBER, d);
		end else if (b == CH_AMP || b == CH_TILDE || b == CH_CARET || b == CH_USCORE
				|| b == CH_HASH) begin
			note_class(b, CLS_SPECIAL, d);
		end else begin
			note_class(b, CLS_DEFAULT, d);
		end
	endfunction

	function void math_byte(input logic [7:0] b, input logic d);
		if (lx_esc) begin
			note_class(b, CLS_MATH, d);
			lx_esc = 1'b0;
		end else if (b == CH_NL) begin
			lex_plain(b, d);
		end else if (b == CH_BSLASH) begin
			note_class(b, CLS_MATH, d);
			lx_esc = 1'b1;
		end else if (b == CH_DOLLAR) begin
			note_class(b, CLS_MATH, d);
			lx_mode = lx_dbl ? MODE_MATH_TAIL : MODE_NORMAL;
		end else begin
			note_class(b, CLS_MATH, d);
		end
	endfunction

	function void lex_byte(input logic [7:0] b, input logic d);
		int k;
		case (lx_mode)
			MODE_COMMENT: begin
				if (b == CH_NL) lex_plain(b, d);
				else note_class(b, CLS_COMMENT, d);
			end
			MODE_CMD_START: begin
				if (is_letter(b)) begin
					note_class(b, CLS_COMMAND, d);
					lx_match = (b == CH_LC_B) ? MATCH_B : ((b == CH_LC_E) ? MATCH_E : MATCH_NONE);
					lx_mode  = MODE_CMD_WORD;
				end else if (b != CH_NL) begin
					note_class(b, CLS_COMMAND, d);
					lx_mode = MODE_NORMAL;
				end else begin
					lex_plain(b, d);
				end
			end
			MODE_CMD_WORD: begin
				if (is_letter(b)) begin
					note_class(b, CLS_COMMAND, d);
					lx_match = next_match(lx_match, b);
				end else if (b == CH_STAR) begin
					note_class(b, CLS_COMMAND, d);
					lx_match = MATCH_NONE;
					lx_mode  = MODE_NORMAL;
				end else if (lx_match == MATCH_FULL && b == CH_LBRACE) begin
					note_class(b, CLS_BRACE, d);
					lx_match = MATCH_NONE;
					name_len = 0;
					lx_mode  = MODE_ENV;
				end else begin
					lx_match = MATCH_NONE;
					lex_plain(b, d);
				end
			end
			MODE_MATH_OPEN: begin
				lx_mode = MODE_MATH_BODY;
				lx_esc  = 1'b0;
				if (b == CH_DOLLAR) begin
					note_class(b, CLS_MATH, d);
					lx_dbl = 1'b1;
				end else begin
					lx_dbl = 1'b0;
					math_byte(b, d);
				end
			end
			MODE_MATH_BODY: math_byte(b, d);
			MODE_MATH_TAIL: begin
				note_class(b, CLS_MATH, d);
				lx_mode = MODE_NORMAL;
			end
			MODE_ENV: begin
				if (b == CH_RBRACE) begin
					for (k = 0; k < name_len; k++)
						note_class(name_buf[k], CLS_ENV, 1'b0);
					note_class(b, CLS_BRACE, d);
					name_len = 0;
					lx_mode  = MODE_NORMAL;
				end else if (b == CH_NL || name_len >= NAME_MAX || d) begin
					// name never closed: relex held bytes, then the ending byte
					replay_b.push_back(b);
					replay_l.push_back(d);
					for (k = name_len; k > 0; k--) begin
						replay_b.push_back(name_buf[k - 1]);
						replay_l.push_back(1'b0);
					end
					name_len = 0;
					lx_mode  = MODE_NORMAL;
				end else begin
					name_buf[name_len] = b;
					name_len++;
				end
			end
			default: lex_plain(b, d);
		endcase
	endfunction

	// expected class words for one accepted text word
	function void classify_word(input text_word_t w);
		logic [7:0] b;
		logic       d;
		step_n = 0;
		replay_b.delete();
		replay_l.delete();
		replay_b.push_back(w.text_byte);
		replay_l.push_back(w.range_end);
		while (replay_b.size() != 0) begin
			b = replay_b.pop_back();
			d = replay_l.pop_back();
			lex_byte(b, d);
		end
		if (w.range_end) begin
			lx_mode  = MODE_NORMAL;
			lx_match = MATCH_NONE;
			lx_dbl   = 1'b0;
			lx_esc   = 1'b0;
			name_len = 0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver
	// ------------------------------------------------------------------
	pend_t text_q [$];
	int    sent_n  = 0;
	int    quiet_n = 0;
	logic  calm;

	assign calm = (sent_n >= CALM_LO) && (sent_n < CALM_HI);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_word  <= '0;
			quiet_n    <= 0;
		end else begin
			// a stalled word stays put; otherwise the slot is free
			if (!byte_valid || !byte_stall) begin
				if (text_q.size() != 0 && text_q[0].hold && quiet_n < 2) begin
					byte_valid <= 1'b0;
				end else if (text_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					byte_valid <= 1'b1;
					byte_word  <= text_q[0].w;
					text_q.pop_front();
					sent_n     <= sent_n + 1;
				end else begin
					byte_valid <= 1'b0;
				end
			end
			// count quiet cycles in a row: nothing in flight, nothing expected
			if (class_exp_q.size() == 0 && !byte_valid) quiet_n <= quiet_n + 1;
			else quiet_n <= 0;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predicts on input accept, then checks output accept
	// ------------------------------------------------------------------
	int           err_n = 0;
	int           in_n  = 0;
	int           out_n = 0;
	styled_word_t exp_w;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_stall <= 1'b0;
		end else begin
			if (byte_valid && !byte_stall) begin
				classify_word(byte_word);
				in_n++;
			end
			if (class_valid && !class_stall) begin
				out_n++;
				if (class_exp_q.size() == 0) begin
					if (err_n < REPORT_MAX)
						$display("%0t: unexpected class word: expected none, got byte %h class %0d done %b",
							$time, class_word.styled_byte, class_word.style_class,
							class_word.range_done);
					err_n++;
				end else begin
					exp_w = class_exp_q.pop_front();
					if (class_word.styled_byte !== exp_w.styled_byte
							|| class_word.style_class !== exp_w.style_class
							|| class_word.range_done !== exp_w.range_done) begin
						if (err_n < REPORT_MAX)
							$display("%0t: mismatch: expected byte %h class %0d done %b, got byte %h class %0d done %b",
								$time, exp_w.styled_byte, exp_w.style_class, exp_w.range_done,
								class_word.styled_byte, class_word.style_class,
								class_word.range_done);
						err_n++;
					end
				end
			end
			class_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// run limit
	int cyc_n = 0;

	always @(posedge clk) begin
		cyc_n <= cyc_n + 1;
		if (cyc_n == LIMIT_CYC) begin
			$display("Timeout after %0d cycles, %0d class words still expected",
				cyc_n, class_exp_q.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	int ranges_n   = 0;
	bit range_open = 1'b0;
	bit hold_next  = 1'b0;

	task automatic put_byte(input logic [7:0] b);
		pend_t p;
		p.hold        = hold_next;
		p.w.text_byte = b;
		p.w.range_end = 1'b0;
		text_q.push_back(p);
		hold_next  = 1'b0;
		range_open = 1'b1;
	endtask

	task automatic put_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	// flag the last queued byte as the end of its range
	task automatic end_range();
		pend_t p;
		if (range_open) begin
			p = text_q.pop_back();
			p.w.range_end = 1'b1;
			text_q.push_back(p);
			range_open = 1'b0;
			ranges_n++;
		end
	endtask

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(52);
		if (r < 26) return 8'(CH_LC_A + r);
		if (r < 52) return 8'(CH_UC_A + (r - 26));
		return CH_AT;
	endfunction

	function automatic logic [7:0] rand_mark();
		string s;
		s = "0123456789&~^_#{}[] ";
		return s[$urandom_range(s.len() - 1)];
	endfunction

	task automatic put_env(input bit is_end, input int len, input name_end_t how, input bit plain);
		int i;
		int nest_at;
		if (is_end) put_str("\\end{");
		else put_str("\\begin{");
		// short names sometimes carry a nested \end{ for a second replay
		nest_at = (!plain && len > 3 && len <= 10 && $urandom_range(3) == 0)
			? int'($urandom_range(len - 3)) : -1;
		i = 0;
		while (i < len) begin
			if (i == nest_at) begin
				put_str("\\end{");
				i += 5;
			end else begin
				if (!plain && $urandom_range(4) == 0) put_byte(8'($urandom_range(255)));
				else put_byte(rand_letter());
				i++;
			end
		end
		case (how)
			END_BRACE: put_byte(CH_RBRACE);
			END_NL:    put_byte(CH_NL);
			END_EXTRA: put_byte(rand_letter());
			END_RANGE: end_range();
			default: ;
		endcase
	endtask

	task automatic put_token();
		int        i;
		int        n;
		int        len;
		name_end_t how;
		string     miss [8];
		miss = '{"\\begi{", "\\beginn{", "\\en{", "\\endx{", "\\begin*{", "\\begin {",
			"\\Begin{", "\\\n"};
		case ($urandom_range(11))
			0: begin
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++) put_byte(8'($urandom_range(255)));
			end
			1: begin
				put_byte(CH_PERCENT);
				n = $urandom_range(5);
				for (i = 0; i < n; i++) put_byte(8'($urandom_range(255)));
				if ($urandom_range(3) != 0) put_byte(CH_NL);
			end
			2: begin
				put_byte(CH_BSLASH);
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++) put_byte(rand_letter());
				if ($urandom_range(2) == 0) put_byte(CH_STAR);
			end
			3: begin
				put_byte(CH_BSLASH);
				put_byte(8'($urandom_range(255)));
			end
			4, 5: begin
				put_byte(CH_DOLLAR);
				if ($urandom_range(1) == 0) put_byte(CH_DOLLAR);
				n = $urandom_range(5);
				for (i = 0; i < n; i++) begin
					case ($urandom_range(9))
						0:       put_byte(CH_BSLASH);
						1:       put_byte(CH_NL);
						2:       put_byte(8'($urandom_range(255)));
						3:       put_byte(rand_mark());
						default: put_byte(rand_letter());
					endcase
				end
				n = $urandom_range(2);
				for (i = 0; i < n; i++) put_byte(CH_DOLLAR);
				put_byte(rand_letter());
			end
			6, 7, 8: begin
				len = ($urandom_range(39) == 0) ? int'($urandom_range(NAME_MAX - 5, NAME_MAX + 2))
					: int'($urandom_range(6));
				case ($urandom_range(9))
					6:       how = END_NL;
					7:       how = END_OPEN;
					8:       how = END_EXTRA;
					9:       how = END_RANGE;
					default: how = END_BRACE;
				endcase
				put_env(1'($urandom_range(1)), len, how, 1'b0);
			end
			9:  put_str(miss[$urandom_range(7)]);
			10: begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++) put_byte(rand_mark());
			end
			default: begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++)
					put_byte(($urandom_range(4) == 0) ? CH_NL : rand_letter());
			end
		endcase
	endtask

	initial begin
		int  dir_n;
		bit  mid_done;

		// directed: comment with a high byte, low/high bytes outside it
		put_byte(CH_PERCENT);
		put_byte(8'hFF);
		put_byte(CH_NL);
		put_byte(8'h00);
		put_byte(8'h80);
		end_range();
		// closed environment name, brace is the last byte
		put_str("\\end{a}");
		end_range();
		// double math with an escaped dollar, then the byte after the close
		put_str("$$\\$$7");
		end_range();
		// name cut off by the end of the range
		put_str("\\end{q");
		end_range();
		dir_n = text_q.size();

		// after a full drain the longest names come first, then the random part
		hold_next = 1'b1;
		put_env(1'b0, NAME_MAX, END_BRACE, 1'b1);
		end_range();
		put_env(1'b1, NAME_MAX, END_EXTRA, 1'b1);
		end_range();
		mid_done = 1'b0;
		while (text_q.size() < dir_n + RAND_ITEMS) begin
			if (!mid_done && text_q.size() >= dir_n + MID_HOLD) begin
				hold_next = 1'b1;
				mid_done  = 1'b1;
			end
			put_token();
			if ($urandom_range(4) == 0) end_range();
		end
		end_range();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (text_q.size() != 0 || byte_valid) @(posedge clk);
		while (class_exp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		#1;
		$display("Covered %0d text words over %0d ranges (held, released and replayed names,",
			in_n, ranges_n);
		$display("math, comments, commands); %0d class words checked, %0d errors",
			out_n, err_n + class_exp_q.size());
		if (err_n == 0 && class_exp_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
